// File: src/jtpi_pkg.sv
// Shared types, constants and helpers for the joint torque PI controller.
// Used by the serial multiplier, the top level and the testbench.
// No dependencies.
package jtpi_pkg;

  // Default joint count (top-level parameter default)
  localparam int unsigned NUM_JOINTS_DEF = 7;

  // Field widths
  localparam int unsigned JointW  = 3;
  localparam int unsigned TorqueW = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned FGainW  = 17;
  localparam int unsigned GainW   = 24;

  // Serial multiplier: signed multiplicand, unsigned multiplier, product
  localparam int unsigned McW = 34;
  localparam int unsigned MpW = 24;
  localparam int unsigned PW  = McW + MpW;

  // Fixed-point shifts
  localparam int unsigned IntegShift = 20;
  localparam int unsigned GainShift  = 16;

  // Register reset values
  localparam logic [FGainW-1:0] FILTER_GAIN_RST = 17'd65536;
  localparam logic [FGainW-1:0] FILTER_GAIN_ONE = 17'd65536;
  localparam logic [GainW-1:0]  PROP_GAIN_RST   = 24'd65536;
  localparam logic [GainW-1:0]  INTEG_GAIN_RST  = 24'd131072;
  localparam logic              PI_ENABLE_RST   = 1'b1;

  // Config port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FILTER_GAIN = 2'd0,
    REG_PROP_GAIN   = 2'd1,
    REG_INTEG_GAIN  = 2'd2,
    REG_PI_ENABLE   = 2'd3
  } cfg_reg_e;

  // Item commands
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_CONTROL = 1'b1;

  // Controller sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_INT_GO,
    S_INT_WAIT,
    S_FILT_GO,
    S_FILT_WAIT,
    S_KP_GO,
    S_KP_WAIT,
    S_KI_GO,
    S_KI_WAIT,
    S_DONE
  } state_e;

  // Stream payloads
  typedef struct packed {
    logic                      command;
    logic [JointW-1:0]         joint;
    logic signed [TorqueW-1:0] measured_torque;
    logic signed [TorqueW-1:0] target_torque;
    logic [PeriodW-1:0]        period;
    logic                      stop;
  } in_item_t;

  typedef struct packed {
    logic [JointW-1:0]         joint_out;
    logic signed [TorqueW-1:0] torque_command;
    logic                      finished;
  } out_item_t;

  // Multiplier request / response
  typedef struct packed {
    logic                  start;
    logic signed [McW-1:0] mcand;
    logic [MpW-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [PW-1:0] prod;
  } mul_rsp_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [TorqueW-1:0] sat32(input logic signed [PW-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[PW-1:TorqueW-1];
    all_zero = ~|v[PW-1:TorqueW-1];
    if (all_one || all_zero) begin
      sat32 = v[TorqueW-1:0];
    end else if (v[PW-1]) begin
      sat32 = {1'b1, {(TorqueW-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(TorqueW-1){1'b1}}};
    end
  endfunction

endpackage

// File: src/jtpi_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from jtpi_pkg.
interface jtpi_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/joint_torque_pi_with_target_filter_top.sv
// Per-joint torque PI controller with a first-order target filter (top level).
// Depends on jtpi_pkg, jtpi_stream_if and jtpi_sermul.
//
// Usage:
//   in_i  : sink stream of jtpi_pkg::in_item_t (one item per joint step).
//   out_o : source stream of jtpi_pkg::out_item_t, exactly one result per item.
//   cfg_* : write-only register port (filter gain, P gain, I gain, PI enable);
//           the user must write it only while the block is idle; the block does not enforce this.
// A capture item (command 0) stores the measured torque as the joint's bias and
// clears its integral and filtered target; a control item (command 1) runs the
// integral update, the target filter and the PI law, each product on one shared
// bit-serial multiplier that retires one multiplier bit per cycle.
// A capture item or an out-of-range joint passes from the input register through the
// evaluation step straight to the done step; a control item runs its four products
// after the evaluation step, each until no set bits of its multiplier operand remain:
// period, filter gain, P gain, I gain, in that order.
// One item is in flight at a time; the next item can be accepted while the previous
// result still sits in the output register.
// Reset clears all joint state and loads default gains. A stalled receiver holds
// the result in the output register; the sequencer then waits in its final step.
module joint_torque_pi_with_target_filter_top #(
  parameter int unsigned NUM_JOINTS = jtpi_pkg::NUM_JOINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  jtpi_stream_if.sink                   in_i,
  jtpi_stream_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic [jtpi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jtpi_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned TW   = jtpi_pkg::TorqueW;
  localparam int unsigned PW   = jtpi_pkg::PW;
  localparam int unsigned McW  = jtpi_pkg::McW;
  localparam int unsigned MpW  = jtpi_pkg::MpW;

  // Configuration registers
  logic [jtpi_pkg::FGainW-1:0] filter_gain_q;
  logic [jtpi_pkg::GainW-1:0]  prop_gain_q;
  logic [jtpi_pkg::GainW-1:0]  integ_gain_q;
  logic                        pi_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_gain_q <= jtpi_pkg::FILTER_GAIN_RST;
      prop_gain_q   <= jtpi_pkg::PROP_GAIN_RST;
      integ_gain_q  <= jtpi_pkg::INTEG_GAIN_RST;
      pi_enable_q   <= jtpi_pkg::PI_ENABLE_RST;
    end else if (cfg_we_i) begin
      case (jtpi_pkg::cfg_reg_e'(cfg_idx_i))
        jtpi_pkg::REG_FILTER_GAIN: filter_gain_q <= cfg_wdata_i[jtpi_pkg::FGainW-1:0];
        jtpi_pkg::REG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i;
        jtpi_pkg::REG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata_i;
        jtpi_pkg::REG_PI_ENABLE:   pi_enable_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Effective gains
  logic [jtpi_pkg::FGainW-1:0] g_eff;
  logic [jtpi_pkg::GainW-1:0]  kp_eff;
  logic [jtpi_pkg::GainW-1:0]  ki_eff;

  assign g_eff  = (filter_gain_q > jtpi_pkg::FILTER_GAIN_ONE) ?
                  jtpi_pkg::FILTER_GAIN_ONE : filter_gain_q;
  assign kp_eff = pi_enable_q ? prop_gain_q  : '0;
  assign ki_eff = pi_enable_q ? integ_gain_q : '0;

  // Sequencer and datapath registers
  jtpi_pkg::state_e  state_q, state_d;
  jtpi_pkg::in_item_t item_q;
  logic signed [McW-1:0] ext_q;
  logic signed [TW-1:0]  integ_q;
  logic signed [TW-1:0]  filt_q;
  logic signed [PW-1:0]  sum_q;
  logic signed [TW-1:0]  res_q;
  logic                  fin_q;
  logic                  out_valid_q;
  jtpi_pkg::out_item_t   out_data_q;

  // Per-joint state
  logic signed [TW-1:0] bias_q       [NUM_JOINTS];
  logic signed [TW-1:0] integ_store_q[NUM_JOINTS];
  logic signed [TW-1:0] filt_store_q [NUM_JOINTS];

  logic [IdxW-1:0]      idx;
  logic                 joint_ok;
  logic signed [TW-1:0] bias_rd;
  logic signed [TW-1:0] integ_rd;
  logic signed [TW-1:0] filt_rd;

  assign idx      = IdxW'(item_q.joint);
  assign joint_ok = (32'(item_q.joint) < NUM_JOINTS);
  assign bias_rd  = bias_q[idx];
  assign integ_rd = integ_store_q[idx];
  assign filt_rd  = filt_store_q[idx];

  // Shared multiplier
  jtpi_pkg::mul_req_t mul_req;
  jtpi_pkg::mul_rsp_t mul_rsp;

  jtpi_sermul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  logic in_xfer;
  logic out_free;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jtpi_pkg::S_IDLE:      if (in_i.valid) state_d = jtpi_pkg::S_EVAL;
      jtpi_pkg::S_EVAL: begin
        if (!joint_ok || item_q.command == jtpi_pkg::CMD_CAPTURE) begin
          state_d = jtpi_pkg::S_DONE;
        end else begin
          state_d = jtpi_pkg::S_INT_GO;
        end
      end
      jtpi_pkg::S_INT_GO:    state_d = jtpi_pkg::S_INT_WAIT;
      jtpi_pkg::S_INT_WAIT:  if (mul_rsp.done) state_d = jtpi_pkg::S_FILT_GO;
      jtpi_pkg::S_FILT_GO:   state_d = jtpi_pkg::S_FILT_WAIT;
      jtpi_pkg::S_FILT_WAIT: if (mul_rsp.done) state_d = jtpi_pkg::S_KP_GO;
      jtpi_pkg::S_KP_GO:     state_d = jtpi_pkg::S_KP_WAIT;
      jtpi_pkg::S_KP_WAIT:   if (mul_rsp.done) state_d = jtpi_pkg::S_KI_GO;
      jtpi_pkg::S_KI_GO:     state_d = jtpi_pkg::S_KI_WAIT;
      jtpi_pkg::S_KI_WAIT:   if (mul_rsp.done) state_d = jtpi_pkg::S_DONE;
      jtpi_pkg::S_DONE:      if (out_free) state_d = jtpi_pkg::S_IDLE;
      default:               state_d = jtpi_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and multiplier requests
  always_comb begin
    in_i.ready     = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    case (state_q)
      jtpi_pkg::S_IDLE:    in_i.ready = 1'b1;
      jtpi_pkg::S_INT_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = McW'(filt_rd) - ext_q;
        mul_req.mplier = MpW'(item_q.period);
      end
      jtpi_pkg::S_FILT_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = McW'(item_q.target_torque) - McW'(filt_rd);
        mul_req.mplier = MpW'(g_eff);
      end
      jtpi_pkg::S_KP_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = McW'(filt_q) - ext_q;
        mul_req.mplier = kp_eff;
      end
      jtpi_pkg::S_KI_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = McW'(integ_q);
        mul_req.mplier = ki_eff;
      end
      default: ;
    endcase
  end

  // Product post-processing (floor shifts)
  logic signed [PW-1:0] integ_sum;
  logic signed [PW-1:0] filt_sum;
  logic signed [PW-1:0] total_sum;

  assign integ_sum = PW'(integ_rd) + (mul_rsp.prod >>> jtpi_pkg::IntegShift);
  assign filt_sum  = PW'(filt_rd)  + (mul_rsp.prod >>> jtpi_pkg::GainShift);
  assign total_sum = sum_q         + (mul_rsp.prod >>> jtpi_pkg::GainShift);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jtpi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == jtpi_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-joint state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_JOINTS; i++) begin
        bias_q[i]        <= '0;
        integ_store_q[i] <= '0;
        filt_store_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        jtpi_pkg::S_EVAL: begin
          if (joint_ok && item_q.command == jtpi_pkg::CMD_CAPTURE) begin
            bias_q[idx]        <= item_q.measured_torque;
            integ_store_q[idx] <= '0;
            filt_store_q[idx]  <= '0;
          end
        end
        jtpi_pkg::S_INT_WAIT: begin
          if (mul_rsp.done) integ_store_q[idx] <= jtpi_pkg::sat32(integ_sum);
        end
        jtpi_pkg::S_FILT_WAIT: begin
          if (mul_rsp.done) filt_store_q[idx] <= filt_sum[TW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) item_q <= in_i.data;
    case (state_q)
      jtpi_pkg::S_EVAL: begin
        ext_q <= McW'(item_q.measured_torque) - McW'(bias_rd);
        res_q <= '0;
        fin_q <= 1'b0;
      end
      jtpi_pkg::S_INT_WAIT:  if (mul_rsp.done) integ_q <= jtpi_pkg::sat32(integ_sum);
      jtpi_pkg::S_FILT_WAIT: if (mul_rsp.done) filt_q  <= filt_sum[TW-1:0];
      jtpi_pkg::S_KP_WAIT: begin
        if (mul_rsp.done) sum_q <= PW'(filt_q) + (mul_rsp.prod >>> jtpi_pkg::GainShift);
      end
      jtpi_pkg::S_KI_WAIT: begin
        if (mul_rsp.done) begin
          res_q <= item_q.stop ? '0 : jtpi_pkg::sat32(total_sum);
          fin_q <= item_q.stop;
        end
      end
      jtpi_pkg::S_DONE: begin
        if (out_free) begin
          out_data_q.joint_out      <= item_q.joint;
          out_data_q.torque_command <= res_q;
          out_data_q.finished       <= fin_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // A finished result always carries a zero command
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.finished) |-> (out_o.data.torque_command == '0))
    else $error("finished result with nonzero command");

  // Out-of-range joints yield a zero, unfinished result
  a_bad_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (32'(out_o.data.joint_out) >= NUM_JOINTS))
      |-> (out_o.data.torque_command == '0 && !out_o.data.finished))
    else $error("out-of-range joint produced a command");

  // Multiplier completes only while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == jtpi_pkg::S_INT_WAIT || state_q == jtpi_pkg::S_FILT_WAIT ||
                      state_q == jtpi_pkg::S_KP_WAIT  || state_q == jtpi_pkg::S_KI_WAIT))
    else $error("multiplier done outside a wait step");

  // An input transfer is followed by the evaluation step
  a_xfer_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == jtpi_pkg::S_EVAL))
    else $error("input transfer not followed by evaluation");

endmodule

// File: src/jtpi_sermul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
// One multiplier bit per cycle; stops as soon as no set bits remain. Uses jtpi_pkg.
module jtpi_sermul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jtpi_pkg::mul_req_t req_i,
  output jtpi_pkg::mul_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic signed [jtpi_pkg::PW-1:0] mc_q, mc_d;
  logic [jtpi_pkg::MpW-1:0]       mp_q, mp_d;
  logic signed [jtpi_pkg::PW-1:0] acc_q, acc_d;
  logic                           fin;

  // Done once the remaining multiplier bits are all zero
  assign fin = busy_q && (mp_q == '0);

  // Shift-add step
  always_comb begin
    busy_d = busy_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mc_d   = jtpi_pkg::PW'(req_i.mcand);
      mp_d   = req_i.mplier;
      acc_d  = '0;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    acc_q <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = fin;
  assign rsp_o.prod = acc_q;

  // A new product is only started on an idle unit
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier restarted while busy");

  // Completion drops busy on the next cycle
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && !req_i.start) |=> !busy_q)
    else $error("multiplier still busy after done");

  // An idle unit only becomes busy on a start
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !req_i.start) |=> !busy_q)
    else $error("multiplier became busy without a start");

endmodule

// File: dv/tb_joint_torque_pi_with_target_filter_top.sv
// Self-checking testbench for joint_torque_pi_with_target_filter_top.
// Depends on jtpi_pkg and jtpi_stream_if. A scoreboard class predicts each torque
// command from its own copy of the joint state; plain tasks drive the streams.
module tb_joint_torque_pi_with_target_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jtpi_pkg::*;

  localparam int unsigned NumJoints = NUM_JOINTS_DEF;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 250;
  localparam logic signed [TorqueW-1:0] TqMax = 32'sh7FFF_FFFF;
  localparam logic signed [TorqueW-1:0] TqMin = 32'sh8000_0000;
  localparam longint Q16Max = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16Min = -Q16Max - 1;

  // Receiver behavior per segment
  typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_SLOW} rx_mode_e;

  // Predicts torque commands and checks them in order
  class joint_torque_board;
    logic [FGainW-1:0]         filt_gain;
    logic [GainW-1:0]          kp_gain;
    logic [GainW-1:0]          ki_gain;
    logic                      pi_on;
    logic signed [TorqueW-1:0] bias_mem  [NumJoints];
    logic signed [TorqueW-1:0] integ_mem [NumJoints];
    logic signed [TorqueW-1:0] filt_mem  [NumJoints];
    out_item_t                 expected_cmds [$];
    int unsigned               mismatches;

    function new();
      filt_gain   = FILTER_GAIN_RST;
      kp_gain     = PROP_GAIN_RST;
      ki_gain     = INTEG_GAIN_RST;
      pi_on       = PI_ENABLE_RST;
      mismatches  = 0;
      foreach (bias_mem[i]) begin
        bias_mem[i]  = '0;
        integ_mem[i] = '0;
        filt_mem[i]  = '0;
      end
    endfunction

    function int unsigned pending();
      return expected_cmds.size();
    endfunction

    // Clamp to the signed Q16.16 range
    function logic signed [TorqueW-1:0] clamp_q16(longint v);
      if (v > Q16Max) return TqMax;
      if (v < Q16Min) return TqMin;
      return v[TorqueW-1:0];
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_FILTER_GAIN: filt_gain = data[FGainW-1:0];
        REG_PROP_GAIN:   kp_gain   = data[GainW-1:0];
        REG_INTEG_GAIN:  ki_gain   = data[GainW-1:0];
        REG_PI_ENABLE:   pi_on     = data[0];
        default: ;
      endcase
    endfunction

    // Update the joint state for one transfer and queue the command it yields
    function void note_step(in_item_t it);
      out_item_t   want;
      int unsigned j;
      longint      ext, filt, g, kp, ki, integ, err, cmd;
      j = 32'(it.joint);
      want.joint_out      = it.joint;
      want.torque_command = '0;
      want.finished       = 1'b0;
      if (j < NumJoints) begin
        if (it.command == CMD_CAPTURE) begin
          // stop is ignored on a capture
          bias_mem[j]  = it.measured_torque;
          integ_mem[j] = '0;
          filt_mem[j]  = '0;
        end else begin
          ext  = longint'($signed(it.measured_torque)) - longint'(bias_mem[j]);
          filt = longint'(filt_mem[j]);
          g    = longint'((filt_gain > FILTER_GAIN_ONE) ? FILTER_GAIN_ONE : filt_gain);
          kp   = pi_on ? longint'(kp_gain) : 0;
          ki   = pi_on ? longint'(ki_gain) : 0;
          // integral uses the filtered target from before this step
          integ = longint'(integ_mem[j]) + (((filt - ext) * longint'(it.period)) >>> IntegShift);
          integ_mem[j] = clamp_q16(integ);
          filt = filt + ((g * (longint'($signed(it.target_torque)) - filt)) >>> GainShift);
          filt_mem[j] = filt[TorqueW-1:0];
          err = filt - ext;
          cmd = filt + ((kp * err) >>> GainShift)
              + ((ki * longint'(integ_mem[j])) >>> GainShift);
          if (it.stop) begin
            want.finished = 1'b1;
          end else begin
            want.torque_command = clamp_q16(cmd);
          end
        end
      end
      expected_cmds.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_command(out_item_t got);
      out_item_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("result for joint %0d with nothing outstanding", got.joint_out));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.joint_out !== want.joint_out)
        report($sformatf("joint_out got %0d want %0d", got.joint_out, want.joint_out));
      if (got.torque_command !== want.torque_command)
        report($sformatf("joint %0d torque_command got %h want %h", want.joint_out,
                         got.torque_command, want.torque_command));
      if (got.finished !== want.finished)
        report($sformatf("joint %0d finished got %b want %b", want.joint_out,
                         got.finished, want.finished));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         burst_left;

  joint_torque_board board = new();

  jtpi_stream_if #(.T(in_item_t))  in_if ();
  jtpi_stream_if #(.T(out_item_t)) out_if ();

  joint_torque_pi_with_target_filter_top #(
    .NUM_JOINTS(NumJoints)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #4ms;
    $display("tb_joint_torque_pi_with_target_filter_top: FAIL");
    $finish;
  end

  // Result monitor: sample transfers at the rising edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) board.check_command(out_if.data);
    end
  end

  // Receiver: segments of always ready, random ready, and long stalls
  initial begin
    rx_mode_e    mode;
    int unsigned seg_len;
    int unsigned hold;
    out_if.ready = 1'b0;
    hold = 0;
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 2));
      seg_len = $urandom_range(30, 300);
      repeat (seg_len) begin
        @(negedge clk_i);
        case (mode)
          RX_ALWAYS: out_if.ready = 1'b1;
          RX_RANDOM: out_if.ready = 1'($urandom_range(0, 1));
          default: begin
            if (hold == 0) begin
              out_if.ready = 1'b1;
              hold = $urandom_range(1, 15);
            end else begin
              out_if.ready = 1'b0;
              hold--;
            end
          end
        endcase
      end
    end
  end

  function automatic in_item_t mk_item(logic cmd, logic [JointW-1:0] jnt,
                                       logic signed [TorqueW-1:0] meas,
                                       logic signed [TorqueW-1:0] targ,
                                       logic [PeriodW-1:0] per, logic stp);
    in_item_t it;
    it.command         = cmd;
    it.joint           = jnt;
    it.measured_torque = meas;
    it.target_torque   = targ;
    it.period          = per;
    it.stop            = stp;
    return it;
  endfunction

  // Torque value: extremes, small values around zero, or anything
  function automatic logic signed [TorqueW-1:0] rand_torque();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return TqMax;
    if (sel == 1) return TqMin;
    if (sel == 2) return '0;
    if (sel == 3) return '1;
    if (sel < 12) return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    return $urandom();
  endfunction

  function automatic logic [CfgDataW-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return CfgDataW'($urandom());
    return CfgDataW'($urandom_range(0, 32'h0004_0000));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    it.command = (sel < 6) ? CMD_CAPTURE : CMD_CONTROL;
    it.joint   = ($urandom_range(0, 29) == 0) ? '1 : JointW'($urandom_range(0, NumJoints - 1));
    it.measured_torque = rand_torque();
    it.target_torque   = rand_torque();
    sel = $urandom_range(0, 9);
    if (sel == 0) it.period = '0;
    else if (sel == 1) it.period = '1;
    else if (sel < 5) it.period = PeriodW'($urandom_range(900, 1200));
    else it.period = PeriodW'($urandom());
    it.stop = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // One input transfer; bursts of random length separated by random gaps.
  // Called at a falling edge, returns at a falling edge.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_if.data  = it;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_step(it);
    @(negedge clk_i);
  endtask

  // Stop sending until every outstanding command has come back
  task automatic wait_drain();
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic apply_setting(logic [CfgDataW-1:0] fg, logic [CfgDataW-1:0] kp,
                               logic [CfgDataW-1:0] ki, logic en);
    write_cfg(REG_FILTER_GAIN, fg);
    write_cfg(REG_PROP_GAIN, kp);
    write_cfg(REG_INTEG_GAIN, ki);
    write_cfg(REG_PI_ENABLE, CfgDataW'(en));
    cfg_we = 1'b0;
  endtask

  // Directed items: extremes, stop handling, out-of-range joint
  task automatic run_directed();
    send_item(mk_item(CMD_CAPTURE, 3'd0, TqMax, '0, '0, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd0, TqMin, TqMax, '1, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd0, TqMin, TqMin, '1, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd0, TqMax, TqMin, '0, 1'b1));
    // stop on a capture is ignored
    send_item(mk_item(CMD_CAPTURE, 3'd1, TqMin, TqMax, '1, 1'b1));
    send_item(mk_item(CMD_CONTROL, 3'd1, TqMax, TqMax, '1, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd1, '0, '0, 16'd1, 1'b0));
    // joint beyond the last one leaves all state alone
    send_item(mk_item(CMD_CAPTURE, '1, 32'sd12345, '0, '0, 1'b0));
    send_item(mk_item(CMD_CONTROL, '1, TqMax, TqMin, '1, 1'b1));
    send_item(mk_item(CMD_CONTROL, 3'd2, 32'sh0001_0000, 32'sh0002_0000, 16'd1049, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd2, 32'sh0001_0000, 32'sh0002_0000, 16'd1049, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd3, '1, 32'sd1, '1, 1'b0));
    send_item(mk_item(CMD_CAPTURE, 3'd4, 32'sh0010_0000, '0, '0, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd4, 32'sh0011_0000, 32'shFFF0_0000, 16'd2000, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd4, 32'sh0011_0000, 32'shFFF0_0000, 16'd2000, 1'b1));
    send_item(mk_item(CMD_CONTROL, 3'd5, 32'shAAAA_5555, 32'sh5555_AAAA, 16'hA5A5, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd6, TqMax, TqMax, '1, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd6, TqMin, TqMax, '1, 1'b0));
    send_item(mk_item(CMD_CONTROL, 3'd6, TqMin, TqMax, '1, 1'b0));
    send_item(mk_item(CMD_CAPTURE, 3'd0, '0, '0, '0, 1'b0));
  endtask

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_FILTER_GAIN;
    cfg_wdata   = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    burst_left  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: run_directed();
        1: apply_setting('0, '1, '1, 1'b1);
        // upper data bits land above 1.0 and must act as 1.0
        2: apply_setting('1, '0, '0, 1'b1);
        3: apply_setting(24'd32768, 24'd65536, 24'd131072, 1'b0);
        4: apply_setting(24'd65536, rand_gain(), rand_gain(), 1'b1);
        default: apply_setting(CfgDataW'($urandom_range(0, 32'h1_FFFF)), rand_gain(),
                               rand_gain(), ($urandom_range(0, 3) != 0));
      endcase
      repeat (ItemsPerPhase) begin
        send_item(rand_item());
        if ($urandom_range(0, 199) == 0) wait_drain();
      end
      wait_drain();
    end

    // let any stray result show up
    repeat (100) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_joint_torque_pi_with_target_filter_top: PASS");
    end else begin
      $display("tb_joint_torque_pi_with_target_filter_top: FAIL");
    end
    $finish;
  end

endmodule
